[rtl/core/keyless_proximity_lock_controller_core_macros.svh]
// assertion helpers for the proximity lock controller
`ifndef KEYLESS_PROXIMITY_LOCK_CONTROLLER_CORE_MACROS_SVH
`define KEYLESS_PROXIMITY_LOCK_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define KPL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/kpl_pkg.sv]
package kpl_pkg;

    // configuration port geometry
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // register indexes
    localparam logic [2:0] REG_HANDS_FREE  = 3'd0;
    localparam logic [2:0] REG_TAG_ADDRESS = 3'd1;
    localparam logic [2:0] REG_TIMEOUT     = 3'd2;
    localparam logic [2:0] REG_WELCOME     = 3'd3;
    localparam logic [2:0] REG_UNLOCK      = 3'd4;
    localparam logic [2:0] REG_LOCK        = 3'd5;
    localparam logic [2:0] REG_COOLDOWN    = 3'd6;

    // register reset values
    localparam logic        RST_HANDS_FREE = 1'b1;
    localparam logic [47:0] RST_TAG_ADDR   = 48'd0;
    localparam logic [31:0] RST_TIMEOUT    = 32'd5000;
    localparam logic [7:0]  RST_WELCOME    = 8'hB5;   // -75
    localparam logic [7:0]  RST_UNLOCK     = 8'hBF;   // -65
    localparam logic [7:0]  RST_LOCK       = 8'hAE;   // -82
    localparam logic [31:0] RST_COOLDOWN   = 32'd10000;

    // signal strength of a tag that is not present: -100
    localparam logic [7:0] RSSI_ABSENT = 8'h9C;

    // request kinds
    localparam logic [1:0] REQ_POLL   = 2'd0;
    localparam logic [1:0] REQ_ADVERT = 2'd1;
    localparam logic [1:0] REQ_UNLOCK = 2'd2;

    // hazard flash codes
    localparam logic [1:0] HAZ_NONE   = 2'd0;
    localparam logic [1:0] HAZ_ARM    = 2'd1;
    localparam logic [1:0] HAZ_DISARM = 2'd2;

    typedef struct packed {
        logic        hands_free_enabled;
        logic [47:0] tag_address;
        logic [31:0] absent_after_ms;
        logic [7:0]  welcome_level;
        logic [7:0]  unlock_level;
        logic [7:0]  lock_level;
        logic [31:0] unlock_holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic        ignition_on;
        logic        system_armed;
        logic [47:0] adv_address;
        logic [7:0]  adv_rssi;
    } item_t;

    typedef struct packed {
        logic       armed;
        logic       welcome_light;
        logic [1:0] hazard_flashes;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } res_flow_t;

endpackage

[rtl/core/kpl_regs.sv]
module kpl_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kpl_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpl_pkg::DATA_W-1:0]   pwdata,
    output logic [kpl_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output kpl_pkg::cfg_t                cfg
);

    kpl_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hands_free_enabled <= kpl_pkg::RST_HANDS_FREE;
            cfg_reg.tag_address        <= kpl_pkg::RST_TAG_ADDR;
            cfg_reg.absent_after_ms    <= kpl_pkg::RST_TIMEOUT;
            cfg_reg.welcome_level      <= kpl_pkg::RST_WELCOME;
            cfg_reg.unlock_level       <= kpl_pkg::RST_UNLOCK;
            cfg_reg.lock_level         <= kpl_pkg::RST_LOCK;
            cfg_reg.unlock_holdoff_ms  <= kpl_pkg::RST_COOLDOWN;
        end
        else if (wr_en)
        begin
            case (reg_index)
                kpl_pkg::REG_HANDS_FREE:  cfg_reg.hands_free_enabled <= pwdata[0];
                kpl_pkg::REG_TAG_ADDRESS: cfg_reg.tag_address        <= pwdata[47:0];
                kpl_pkg::REG_TIMEOUT:     cfg_reg.absent_after_ms    <= pwdata[31:0];
                kpl_pkg::REG_WELCOME:     cfg_reg.welcome_level      <= pwdata[7:0];
                kpl_pkg::REG_UNLOCK:      cfg_reg.unlock_level       <= pwdata[7:0];
                kpl_pkg::REG_LOCK:        cfg_reg.lock_level         <= pwdata[7:0];
                kpl_pkg::REG_COOLDOWN:    cfg_reg.unlock_holdoff_ms  <= pwdata[31:0];
                default:                  ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_index)
            kpl_pkg::REG_HANDS_FREE:  prdata = {63'd0, cfg_reg.hands_free_enabled};
            kpl_pkg::REG_TAG_ADDRESS: prdata = {16'd0, cfg_reg.tag_address};
            kpl_pkg::REG_TIMEOUT:     prdata = {32'd0, cfg_reg.absent_after_ms};
            kpl_pkg::REG_WELCOME:     prdata = {56'd0, cfg_reg.welcome_level};
            kpl_pkg::REG_UNLOCK:      prdata = {56'd0, cfg_reg.unlock_level};
            kpl_pkg::REG_LOCK:        prdata = {56'd0, cfg_reg.lock_level};
            kpl_pkg::REG_COOLDOWN:    prdata = {32'd0, cfg_reg.unlock_holdoff_ms};
            default:                  prdata = '0;
        endcase
    end

endmodule

[rtl/core/kpl_step.sv]
module kpl_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  kpl_pkg::item_t     item,
    input  kpl_pkg::cfg_t      cfg,
    input  logic               out_free,
    output kpl_pkg::res_flow_t flow
);

    // input stage
    logic           stage_valid_reg;
    kpl_pkg::item_t item_reg;
    logic           advance;

    // tag and lock state
    logic [7:0]  tag_rssi_reg,      tag_rssi_next;
    logic        tag_present_reg,   tag_present_next;
    logic [31:0] last_seen_ms_reg,  last_seen_ms_next;
    logic [31:0] last_lock_ms_reg,  last_lock_ms_next;
    logic        prev_ignition_reg, prev_ignition_next;
    logic        light_on_reg,      light_on_next;

    kpl_pkg::res_t res;

    assign advance  = stage_valid_reg && out_free;
    assign s_tready = !stage_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item;
        end
    end

    // step decision
    always_comb
    begin
        logic [31:0] seen_age;
        logic [31:0] lock_age;
        logic        pres;
        logic [7:0]  rssi;
        logic        arm;
        logic        light;
        logic [1:0]  flashes;

        seen_age = item_reg.now_ms - last_seen_ms_reg;
        lock_age = item_reg.now_ms - last_lock_ms_reg;
        pres     = tag_present_reg;
        rssi     = tag_rssi_reg;
        arm      = item_reg.system_armed;
        light    = light_on_reg;
        flashes  = kpl_pkg::HAZ_NONE;

        tag_rssi_next      = tag_rssi_reg;
        tag_present_next   = tag_present_reg;
        last_seen_ms_next  = last_seen_ms_reg;
        last_lock_ms_next  = last_lock_ms_reg;
        prev_ignition_next = prev_ignition_reg;

        case (item_reg.req_type)
            kpl_pkg::REQ_ADVERT:
            begin
                if (item_reg.adv_address == cfg.tag_address)
                begin
                    tag_rssi_next     = item_reg.adv_rssi;
                    last_seen_ms_next = item_reg.now_ms;
                    tag_present_next  = 1'b1;
                end
            end
            kpl_pkg::REQ_UNLOCK:
            begin
                last_lock_ms_next = item_reg.now_ms;
            end
            kpl_pkg::REQ_POLL:
            begin
                if (item_reg.ignition_on != prev_ignition_reg)
                begin
                    // ignition edge forces the state
                    prev_ignition_next = item_reg.ignition_on;
                    if (item_reg.ignition_on)
                    begin
                        arm   = 1'b1;
                        light = 1'b0;
                    end
                    else
                    begin
                        arm     = 1'b0;
                        flashes = kpl_pkg::HAZ_DISARM;
                    end
                end
                else if (!item_reg.ignition_on && cfg.hands_free_enabled)
                begin
                    // tag timeout
                    if (seen_age > cfg.absent_after_ms)
                    begin
                        pres = 1'b0;
                        rssi = kpl_pkg::RSSI_ABSENT;
                    end
                    // welcome light
                    if (pres && ($signed(rssi) >= $signed(cfg.welcome_level)) && arm)
                        light = 1'b1;
                    else if (!pres || ($signed(rssi) < $signed(cfg.welcome_level)))
                        light = 1'b0;
                    // proximity disarm or arm
                    if (arm && pres && ($signed(rssi) >= $signed(cfg.unlock_level)))
                    begin
                        if (lock_age >= cfg.unlock_holdoff_ms)
                        begin
                            arm     = 1'b0;
                            light   = 1'b0;
                            flashes = kpl_pkg::HAZ_DISARM;
                        end
                    end
                    else if (!arm && (!pres ||
                             ($signed(rssi) <= $signed(cfg.lock_level))))
                    begin
                        arm               = 1'b1;
                        last_lock_ms_next = item_reg.now_ms;
                        light             = 1'b0;
                        flashes           = kpl_pkg::HAZ_ARM;
                    end
                    tag_present_next = pres;
                    tag_rssi_next    = rssi;
                end
            end
            default: ;
        endcase

        light_on_next      = light;
        res.armed          = arm;
        res.welcome_light  = light;
        res.hazard_flashes = flashes;
    end

    // state update when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_rssi_reg      <= kpl_pkg::RSSI_ABSENT;
            tag_present_reg   <= 1'b0;
            last_seen_ms_reg  <= '0;
            last_lock_ms_reg  <= '0;
            prev_ignition_reg <= 1'b0;
            light_on_reg      <= 1'b0;
        end
        else if (advance)
        begin
            tag_rssi_reg      <= tag_rssi_next;
            tag_present_reg   <= tag_present_next;
            last_seen_ms_reg  <= last_seen_ms_next;
            last_lock_ms_reg  <= last_lock_ms_next;
            prev_ignition_reg <= prev_ignition_next;
            light_on_reg      <= light_on_next;
        end
    end

    assign flow.valid = stage_valid_reg;
    assign flow.res   = res;

endmodule

[rtl/core/kpl_out.sv]
module kpl_out (
    input  logic               clk,
    input  logic               rst_n,
    input  kpl_pkg::res_flow_t flow,
    output logic               out_free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata
);

    logic          m_tvalid_reg;
    kpl_pkg::res_t res_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= flow.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free && flow.valid)
        begin
            res_reg <= flow.res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, res_reg.hazard_flashes, res_reg.welcome_light, res_reg.armed};

endmodule

[rtl/core/keyless_proximity_lock_controller_core.sv]
// an accepted item is held in the input register, and its result is then registered in the result register
// throughput: one item per cycle while the result side takes results, set by the single input-to-result register pass
// backpressure on the result side stalls the input register, no items are dropped
// reset (rst_n, async, active low) restores register defaults, tag absent at -100,
// timestamps zero, ignition low and light off, and empties both stages
`include "keyless_proximity_lock_controller_core_macros.svh"

module keyless_proximity_lock_controller_core (
    input  logic                       clk,
    input  logic                       rst_n,
    // item in
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // now_ms[31:0], ignition_on[32], system_armed[33], adv_address[81:34],
    // adv_rssi[89:82], zero fill[95:90]
    input  logic [95:0]                s_tdata,
    // req_type[1:0]
    input  logic [1:0]                 s_tuser,
    // result out
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // armed[0], welcome_light[1], hazard_flashes[3:2], zero fill[7:4]
    output logic [7:0]                 m_tdata,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kpl_pkg::ADDR_W-1:0] paddr,
    input  logic [kpl_pkg::DATA_W-1:0] pwdata,
    output logic [kpl_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    kpl_pkg::cfg_t      cfg;
    kpl_pkg::item_t     item;
    kpl_pkg::res_flow_t flow;
    logic               out_free;

    // unpack the input transfer
    assign item.req_type     = s_tuser;
    assign item.now_ms       = s_tdata[31:0];
    assign item.ignition_on  = s_tdata[32];
    assign item.system_armed = s_tdata[33];
    assign item.adv_address  = s_tdata[81:34];
    assign item.adv_rssi     = s_tdata[89:82];

    kpl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpl_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item     (item),
        .cfg      (cfg),
        .out_free (out_free),
        .flow     (flow)
    );

    kpl_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .flow     (flow),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // accepted item occupies the input stage next cycle
    `KPL_ASSERT_NEXT(a_stage_load, s_tvalid && s_tready, flow.valid, "accepted item lost")
    // arming flash only with armed result
    `KPL_ASSERT_SAME(a_arm_flash,
        m_tvalid && (m_tdata[3:2] == kpl_pkg::HAZ_ARM),
        m_tdata[0] && !m_tdata[1], "arm flash without armed state")
    // disarming flash only with disarmed result
    `KPL_ASSERT_SAME(a_disarm_flash,
        m_tvalid && (m_tdata[3:2] == kpl_pkg::HAZ_DISARM),
        !m_tdata[0], "disarm flash with armed state")
    // no undefined flash code
    `KPL_ASSERT_SAME(a_flash_code, m_tvalid, m_tdata[3:2] != 2'd3, "bad hazard flash code")

endmodule
